>>> hw/rtl/fsrp_pkg.sv
package fsrp_pkg;

  // Fixed payload widths of the request and response channels
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_SEARCH = 3'd2,
    REQ_PAL    = 3'd3,
    REQ_ROT    = 3'd4
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_RESP
  } state_e;

endpackage

>>> hw/rtl/fsrp_req_if.sv
interface fsrp_req_if import fsrp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [REQ_W-1:0]            req_type;
  logic signed [IN_DATA_W-1:0] data_in;
  logic [AMT_W-1:0]            rotate_amount;

  modport source (output valid, output req_type, output data_in, output rotate_amount,
                  input ready);
  modport sink   (input valid, input req_type, input data_in, input rotate_amount,
                  output ready);
endinterface

>>> hw/rtl/fsrp_rsp_if.sv
interface fsrp_rsp_if import fsrp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [IN_DATA_W-1:0] data_out;
  logic                        found;
  logic                        is_palindrome;
  logic [OCC_W-1:0]            occupancy;
  logic [STATUS_W-1:0]         status;

  modport source (output valid, output data_out, output found, output is_palindrome,
                  output occupancy, output status, input ready);
  modport sink   (input valid, input data_out, input found, input is_palindrome,
                  input occupancy, input status, output ready);
endinterface

>>> hw/rtl/fifo_with_search_rotate_palindrome_unit.sv
// Enqueue, dequeue, unused codes and any request on an empty queue go straight to the
// response; a search reads every entry, a palindrome check compares occupancy/2 pairs,
// and a rotate by a nonzero amount moves amount mod occupancy entries from front to rear.
// One request at a time: the next is accepted once the response is registered, as the
// memory read pipeline and the bit-serial remainder unit serve one request.
// Reset (async, low) empties the queue and clears control; stored words stay undefined.
module fifo_with_search_rotate_palindrome_unit import fsrp_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsrp_req_if.sink    req_i,
  fsrp_rsp_if.source  rsp_o
);

  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned DIV_CNT_W = $clog2(AMT_W + 1);

  localparam logic [PTR_W-1:0]     PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(DEPTH);
  localparam logic [DIV_CNT_W-1:0] DIV_LEN  = DIV_CNT_W'(AMT_W);

  // Ring pointer steps; DEPTH need not be a power of two
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [PTR_W-1:0]       head_q, head_d;       // front entry
  logic [PTR_W-1:0]       tail_q, tail_d;       // next free slot
  logic [CNT_W-1:0]       count_q, count_d;
  req_type_e              op_q, op_d;           // request under way
  logic [DATA_WIDTH-1:0]  key_q, key_d;         // value searched for
  logic [AMT_W-1:0]       amt_q, amt_d;         // dividend, shifted out MSB first
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]       rem_q, rem_d;         // partial remainder
  logic [CNT_W-1:0]       steps_q, steps_d;     // memory reads still to issue
  logic [PTR_W-1:0]       ptr_a_q, ptr_a_d;     // walks forward from the front
  logic [PTR_W-1:0]       ptr_b_q, ptr_b_d;     // walks back from the rear
  logic                   pipe_vld_q, pipe_vld_d; // read data is valid this cycle
  logic                   res_found_q, res_found_d;
  logic                   res_pal_q, res_pal_d;
  status_e                res_status_q, res_status_d;
  logic                   res_mem_q, res_mem_d;  // response data comes from read port A

  logic                   rsp_valid_q, rsp_valid_d;
  logic [IN_DATA_W-1:0]   rsp_data_q, rsp_data_d;
  logic                   rsp_found_q, rsp_found_d;
  logic                   rsp_pal_q, rsp_pal_d;
  logic [OCC_W-1:0]       rsp_occ_q, rsp_occ_d;
  status_e                rsp_status_q, rsp_status_d;

  // ---------------------------------------------------------------------------
  // Entry memory: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0]  mem_q [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_a_q, rd_b_q;
  logic                   wr_en, rd_en_a, rd_en_b;
  logic [PTR_W-1:0]       wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_WIDTH-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a_q <= mem_q[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and request decode
  // ---------------------------------------------------------------------------
  logic                  req_fire;
  logic                  rsp_free;
  req_type_e             in_type;
  logic [DATA_WIDTH-1:0] in_word;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign in_type     = req_type_e'(req_i.req_type);
  // Only the low DATA_WIDTH bits of the 32-bit value are held and compared
  assign in_word     = DATA_WIDTH'($unsigned(req_i.data_in));

  // Remainder unit: one restoring step per cycle, one step for each bit of the amount
  logic [CNT_W:0]   rem_shift;
  logic [CNT_W:0]   rem_cnt_ext;
  logic [CNT_W-1:0] rem_next;

  assign rem_shift   = {rem_q, amt_q[AMT_W-1]};
  assign rem_cnt_ext = {1'b0, count_q};
  assign rem_next    = (rem_shift >= rem_cnt_ext) ? CNT_W'(rem_shift - rem_cnt_ext)
                                                  : CNT_W'(rem_shift);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (in_type)
            REQ_SEARCH, REQ_PAL: state_d = (count_q == '0) ? ST_RESP : ST_WALK;
            REQ_ROT: begin
              state_d = (count_q != '0 && req_i.rotate_amount != '0) ? ST_DIV : ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(1)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // finished once every read has been issued and the last one consumed
        if (steps_q == '0 && !pipe_vld_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    op_d         = op_q;
    key_d        = key_q;
    amt_d        = amt_q;
    div_cnt_d    = div_cnt_q;
    rem_d        = rem_q;
    steps_d      = steps_q;
    ptr_a_d      = ptr_a_q;
    ptr_b_d      = ptr_b_q;
    pipe_vld_d   = 1'b0;
    res_found_d  = res_found_q;
    res_pal_d    = res_pal_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    wr_en        = 1'b0;
    wr_addr      = tail_q;
    wr_data      = rd_a_q;
    rd_en_a      = 1'b0;
    rd_addr_a    = ptr_a_q;
    rd_en_b      = 1'b0;
    rd_addr_b    = ptr_b_q;

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_data_d   = rsp_data_q;
    rsp_found_d  = rsp_found_q;
    rsp_pal_d    = rsp_pal_q;
    rsp_occ_d    = rsp_occ_q;
    rsp_status_d = rsp_status_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d         = in_type;
          key_d        = in_word;
          amt_d        = req_i.rotate_amount;
          div_cnt_d    = DIV_LEN;
          rem_d        = '0;
          steps_d      = '0;
          ptr_a_d      = head_q;
          ptr_b_d      = ptr_dec(tail_q);
          res_found_d  = 1'b0;
          res_pal_d    = 1'b0;
          res_status_d = STATUS_OK;
          res_mem_d    = 1'b0;
          case (in_type)
            REQ_ENQ: begin
              if (count_q == CNT_FULL) begin
                res_status_d = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = tail_q;
                wr_data = in_word;
                tail_d  = ptr_inc(tail_q);
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_DEQ: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                rd_en_a   = 1'b1;
                rd_addr_a = head_q;
                head_d    = ptr_inc(head_q);
                count_d   = count_q - CNT_W'(1);
                res_mem_d = 1'b1;
              end
            end
            REQ_SEARCH: steps_d = count_q;
            REQ_PAL: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                res_pal_d = 1'b1;
                steps_d   = count_q >> 1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        rem_d     = rem_next;
        amt_d     = amt_q << 1;
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(1)) begin
          steps_d = rem_next;
        end
      end

      ST_WALK: begin
        // issue side
        if (steps_q != '0) begin
          pipe_vld_d = 1'b1;
          rd_en_a    = 1'b1;
          rd_addr_a  = ptr_a_q;
          ptr_a_d    = ptr_inc(ptr_a_q);
          steps_d    = steps_q - CNT_W'(1);
          if (op_q == REQ_PAL) begin
            rd_en_b   = 1'b1;
            rd_addr_b = ptr_b_q;
            ptr_b_d   = ptr_dec(ptr_b_q);
          end
          if (op_q == REQ_ROT) begin
            head_d = ptr_inc(head_q);
          end
        end
        // consume side, in the cycle after the read; a rotate writes the popped word at the
        // rear, which never lands on the slot being read in the same cycle
        if (pipe_vld_q) begin
          case (op_q)
            REQ_SEARCH: begin
              if (rd_a_q == key_q) begin
                res_found_d = 1'b1;
              end
            end
            REQ_PAL: begin
              if (rd_a_q != rd_b_q) begin
                res_pal_d = 1'b0;
              end
            end
            REQ_ROT: begin
              wr_en   = 1'b1;
              wr_addr = tail_q;
              wr_data = rd_a_q;
              tail_d  = ptr_inc(tail_q);
            end
            default: ;
          endcase
        end
      end

      ST_RESP: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_data_d   = res_mem_q ? IN_DATA_W'(rd_a_q) : '0;
          rsp_found_d  = res_found_q;
          rsp_pal_d    = res_pal_q;
          rsp_occ_d    = OCC_W'(count_q);
          rsp_status_d = res_status_q;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      op_q        <= REQ_ENQ;
      div_cnt_q   <= '0;
      steps_q     <= '0;
      pipe_vld_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      op_q        <= op_d;
      div_cnt_q   <= div_cnt_d;
      steps_q     <= steps_d;
      pipe_vld_q  <= pipe_vld_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    amt_q        <= amt_d;
    rem_q        <= rem_d;
    ptr_a_q      <= ptr_a_d;
    ptr_b_q      <= ptr_b_d;
    res_found_q  <= res_found_d;
    res_pal_q    <= res_pal_d;
    res_status_q <= res_status_d;
    res_mem_q    <= res_mem_d;
    rsp_data_q   <= rsp_data_d;
    rsp_found_q  <= rsp_found_d;
    rsp_pal_q    <= rsp_pal_d;
    rsp_occ_q    <= rsp_occ_d;
    rsp_status_q <= rsp_status_d;
  end

  // ---------------------------------------------------------------------------
  // Response channel
  // ---------------------------------------------------------------------------
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.data_out      = rsp_data_q;
  assign rsp_o.found         = rsp_found_q;
  assign rsp_o.is_palindrome = rsp_pal_q;
  assign rsp_o.occupancy     = rsp_occ_q;
  assign rsp_o.status        = rsp_status_q;

endmodule
